// ===== sv/lbfd_pkg.sv =====
// Shared types and constants of the lane bus frame deframer.
// Used by lbfd_front, lbfd_queue and the top level; depends on nothing.
`default_nettype none

package lbfd_pkg;

    // Field widths of the frame format
    localparam int MAX_LANES  = 16;
    localparam int ADDR_BITS  = 16;
    localparam int COUNT_BITS = 12;
    localparam int LEN_BITS   = 6;
    localparam int VALUE_BITS = 12;
    localparam int TYPE_BITS  = 1;

    localparam int LANE_W    = 16;
    localparam int LCNT_W    = 5;
    localparam int SPAN_W    = 11;
    localparam int MIDX_W    = 11;
    localparam int IIDX_W    = 5;
    localparam int WORD_W    = 16;
    localparam int KIND_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Result queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_HDR   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LEN   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_VAL   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_END   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNSUP = 3'd4;

    typedef struct packed {
        logic [LCNT_W-1:0]           lane_count;
        logic signed [ADDR_BITS-1:0] own_first;
        logic [SPAN_W-1:0]           own_span;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0]            kind;
        logic                         addressed;
        logic signed [ADDR_BITS-1:0]  src_first;
        logic signed [COUNT_BITS-1:0] msg_total;
        logic signed [ADDR_BITS-1:0]  dest;
        logic [MIDX_W-1:0]            msg_index;
        logic [IIDX_W-1:0]            item_index;
        logic signed [WORD_W-1:0]     word;
        logic                         last;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/lbfd_front.sv =====
// Front of the deframer: assembles lane beats into fields and walks the frame.
// Depends on lbfd_pkg; produces at most one result word per accepted beat.
`default_nettype none

module lbfd_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             beat_valid,
    input  wire logic [lbfd_pkg::LANE_W-1:0] lanes,
    input  wire lbfd_pkg::cfg_t   cfg,
    output logic                  ev_valid,
    output lbfd_pkg::res_t        ev
);
    import lbfd_pkg::*;

    localparam logic [2:0] PH_TYPE  = 3'd0;
    localparam logic [2:0] PH_SRC   = 3'd1;
    localparam logic [2:0] PH_COUNT = 3'd2;
    localparam logic [2:0] PH_DEST  = 3'd3;
    localparam logic [2:0] PH_LEN   = 3'd4;
    localparam logic [2:0] PH_VAL   = 3'd5;
    localparam logic [2:0] PH_END   = 3'd6;
    localparam logic [2:0] PH_SPARE = 3'd7;

    logic [2:0]                   phase_reg, phase_next;
    logic [LANE_W-1:0]            acc_reg, acc_next;
    logic [4:0]                   taken_reg, taken_next;
    logic signed [ADDR_BITS-1:0]  hdr_src_reg, hdr_src_next;
    logic signed [COUNT_BITS-1:0] hdr_count_reg, hdr_count_next;
    logic signed [ADDR_BITS-1:0]  hdr_dest_reg, hdr_dest_next;
    logic                         ours_reg, ours_next;
    logic [MIDX_W-1:0]            msg_reg, msg_next;
    logic [IIDX_W-1:0]            item_reg, item_next;
    logic signed [LEN_BITS-1:0]   cur_len_reg, cur_len_next;
    logic                         type_bad_reg, type_bad_next;

    logic [4:0]          fld_bits;
    logic [4:0]          lc;
    logic [4:0]          need;
    logic [4:0]          take;
    logic [16:0]         take_mask;
    logic [LANE_W-1:0]   shifted;
    logic [LANE_W-1:0]   acc_new;
    logic [4:0]          taken_new;
    logic                done;

    logic signed [ADDR_BITS-1:0]  dest_v;
    logic signed [LEN_BITS-1:0]   len_v;
    logic signed [VALUE_BITS-1:0] val_v;
    logic signed [17:0]           dest_x, lo_x, hi_x;
    logic                         dest_ours;
    logic [MIDX_W:0]              msg_inc;
    logic                         msgs_done;
    logic [IIDX_W:0]              item_inc;
    logic                         items_done;

    // Field width of the current phase
    always_comb
    begin
        unique case (phase_reg)
            PH_TYPE:  fld_bits = 5'(TYPE_BITS);
            PH_SRC:   fld_bits = 5'(ADDR_BITS);
            PH_COUNT: fld_bits = 5'(COUNT_BITS);
            PH_DEST:  fld_bits = 5'(ADDR_BITS);
            PH_LEN:   fld_bits = 5'(LEN_BITS);
            PH_VAL:   fld_bits = 5'(VALUE_BITS);
            default:  fld_bits = 5'(ADDR_BITS);
        endcase
    end

    // Clamp the lane count and gather this beat's bits
    always_comb
    begin
        if (cfg.lane_count == 5'd0)
            lc = 5'd1;
        else if (cfg.lane_count > 5'(MAX_LANES))
            lc = 5'(MAX_LANES);
        else
            lc = cfg.lane_count;
        need      = (fld_bits > taken_reg) ? (fld_bits - taken_reg) : 5'd0;
        take      = (lc < need) ? lc : need;
        take_mask = (17'd1 << take) - 17'd1;
        shifted   = LANE_W'((lanes & take_mask[LANE_W-1:0]) << taken_reg[3:0]);
        acc_new   = acc_reg | shifted;
        taken_new = taken_reg + take;
        done      = (taken_new >= fld_bits);
    end

    // Signed field views and address match
    always_comb
    begin
        dest_v    = $signed(acc_new[ADDR_BITS-1:0]);
        len_v     = $signed(acc_new[LEN_BITS-1:0]);
        val_v     = $signed(acc_new[VALUE_BITS-1:0]);
        dest_x    = 18'(dest_v);
        lo_x      = 18'(cfg.own_first);
        hi_x      = lo_x + $signed({7'd0, cfg.own_span});
        dest_ours = (dest_v == -16'sd1) || ((dest_x >= lo_x) && (dest_x < hi_x));
        msg_inc   = {1'b0, msg_reg} + 12'd1;
        msgs_done = ($signed({1'b0, msg_inc}) >= 13'(hdr_count_reg));
        item_inc  = {1'b0, item_reg} + 6'd1;
        items_done = ($signed({1'b0, item_inc}) >= 7'(cur_len_reg));
    end

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        taken_next     = taken_reg;
        hdr_src_next   = hdr_src_reg;
        hdr_count_next = hdr_count_reg;
        hdr_dest_next  = hdr_dest_reg;
        ours_next      = ours_reg;
        msg_next       = msg_reg;
        item_next      = item_reg;
        cur_len_next   = cur_len_reg;
        type_bad_next  = type_bad_reg;

        ev_valid      = 1'b0;
        ev.kind       = KIND_HDR;
        ev.addressed  = ours_reg;
        ev.src_first  = hdr_src_reg;
        ev.msg_total  = hdr_count_reg;
        ev.dest       = hdr_dest_reg;
        ev.msg_index  = msg_reg;
        ev.item_index = '0;
        ev.word       = '0;
        ev.last       = 1'b0;

        if (beat_valid)
        begin
            if (phase_reg != PH_END && phase_reg != PH_SPARE)
            begin
                // Hold partial bits until the field completes
                acc_next   = done ? '0 : acc_new;
                taken_next = done ? 5'd0 : taken_new;
            end
            unique case (phase_reg)
                PH_TYPE:
                begin
                    if (done)
                    begin
                        type_bad_next = acc_new[0];
                        phase_next    = PH_SRC;
                    end
                end
                PH_SRC:
                begin
                    if (done)
                    begin
                        hdr_src_next = $signed(acc_new[ADDR_BITS-1:0]);
                        phase_next   = PH_COUNT;
                    end
                end
                PH_COUNT:
                begin
                    if (done)
                    begin
                        hdr_count_next = $signed(acc_new[COUNT_BITS-1:0]);
                        phase_next     = PH_DEST;
                    end
                end
                PH_DEST:
                begin
                    if (done)
                    begin
                        hdr_dest_next = dest_v;
                        ours_next     = dest_ours;
                        msg_next      = '0;
                        item_next     = '0;
                        ev_valid      = 1'b1;
                        ev.addressed  = dest_ours;
                        ev.dest       = dest_v;
                        ev.msg_index  = '0;
                        if (type_bad_reg)
                        begin
                            ev.kind    = KIND_UNSUP;
                            phase_next = PH_TYPE;
                        end
                        else
                        begin
                            ev.kind    = KIND_HDR;
                            phase_next = (hdr_count_reg > 12'sd0) ? PH_LEN : PH_END;
                        end
                    end
                end
                PH_LEN:
                begin
                    if (done)
                    begin
                        cur_len_next = len_v;
                        item_next    = '0;
                        ev_valid     = ours_reg;
                        ev.kind      = KIND_LEN;
                        ev.word      = WORD_W'(len_v);
                        if (len_v <= 6'sd0)
                        begin
                            // Empty message: advance to the next one
                            msg_next   = msg_inc[MIDX_W-1:0];
                            phase_next = msgs_done ? PH_END : PH_LEN;
                        end
                        else
                            phase_next = PH_VAL;
                    end
                end
                PH_VAL:
                begin
                    if (done)
                    begin
                        item_next     = item_inc[IIDX_W-1:0];
                        ev_valid      = ours_reg;
                        ev.kind       = KIND_VAL;
                        ev.item_index = item_reg;
                        ev.word       = WORD_W'(val_v);
                        if (items_done)
                        begin
                            msg_next   = msg_inc[MIDX_W-1:0];
                            item_next  = '0;
                            phase_next = msgs_done ? PH_END : PH_LEN;
                        end
                    end
                end
                PH_END:
                begin
                    ev_valid   = 1'b1;
                    ev.kind    = KIND_END;
                    ev.last    = 1'b1;
                    phase_next = PH_TYPE;
                    acc_next   = '0;
                    taken_next = 5'd0;
                end
                default:
                begin
                    phase_next = PH_TYPE;
                    acc_next   = '0;
                    taken_next = 5'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TYPE;
            acc_reg       <= '0;
            taken_reg     <= '0;
            hdr_src_reg   <= '0;
            hdr_count_reg <= '0;
            hdr_dest_reg  <= '0;
            ours_reg      <= 1'b0;
            msg_reg       <= '0;
            item_reg      <= '0;
            cur_len_reg   <= '0;
            type_bad_reg  <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            taken_reg     <= taken_next;
            hdr_src_reg   <= hdr_src_next;
            hdr_count_reg <= hdr_count_next;
            hdr_dest_reg  <= hdr_dest_next;
            ours_reg      <= ours_next;
            msg_reg       <= msg_next;
            item_reg      <= item_next;
            cur_len_reg   <= cur_len_next;
            type_bad_reg  <= type_bad_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_body_only_ours: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_valid && (ev.kind == KIND_LEN || ev.kind == KIND_VAL)) |-> ours_reg)
        else $error("message word emitted for a frame not addressed here");

    a_last_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid |-> (ev.last == (ev.kind == KIND_END)))
        else $error("last flag does not match frame end");

    a_type_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TYPE) |-> (taken_reg == 5'd0))
        else $error("partial bits held while waiting for a type field");
`endif

endmodule

`default_nettype wire

// ===== sv/lbfd_queue.sv =====
// Back of the deframer: short result queue that parts the parser from the reader.
// Depends on lbfd_pkg; the head entry drives the result ports directly.
`default_nettype none

module lbfd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr,
    input  wire lbfd_pkg::res_t wr_data,
    input  wire logic           rd,
    output lbfd_pkg::res_t      head,
    output logic                full,
    output logic                empty
);
    import lbfd_pkg::*;

    res_t                mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                do_wr, do_rd;

    assign full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr)
        else $error("result word pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("queue count beyond depth");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

// ===== sv/lane_bus_frame_deframer_unit.sv =====
// Top level of the lane bus frame deframer: configuration registers,
// parser front (lbfd_front) and result queue (lbfd_queue). Depends on lbfd_pkg.
//
// Usage:
//   Input channel: drive one lane beat on lanes and raise push; the beat is
//   taken at a clock edge with push high and full low. Lane 0 is bit 0.
//   Result channel: while empty is low the oldest result word sits on the
//   result ports; raise pop to take it at the clock edge.
//   Config channel: cfg_index selects lane_count (0), own_first (1) or
//   own_span (2); cfg_ready is always high, so a write lands on any edge
//   with cfg_valid high. Index 3 is ignored. Write only while idle.
// Timing:
//   One beat per cycle while full is low. A beat that yields a result word
//   writes it into the 4-entry queue at that edge, so with the queue empty it
//   shows on the result ports from the next cycle. The parser takes one step per
//   beat; the queue depth bounds how long the reader may stall before full
//   rises and back-pressures the input.
// Reset:
//   rst_n low clears the parser to await a type field, empties the queue
//   and loads lane_count 8, own_first 0, own_span 1.
`default_nettype none

module lane_bus_frame_deframer_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // beat input
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [lbfd_pkg::LANE_W-1:0]        lanes,
    // result output
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [lbfd_pkg::KIND_W-1:0]             kind,
    output logic                                    addressed,
    output logic signed [lbfd_pkg::ADDR_BITS-1:0]   src_first,
    output logic signed [lbfd_pkg::COUNT_BITS-1:0]  msg_total,
    output logic signed [lbfd_pkg::ADDR_BITS-1:0]   dest,
    output logic [lbfd_pkg::MIDX_W-1:0]             msg_index,
    output logic [lbfd_pkg::IIDX_W-1:0]             item_index,
    output logic signed [lbfd_pkg::WORD_W-1:0]      word,
    output logic                                    last,
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lbfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lbfd_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import lbfd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_LANE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_SPAN   = 2'd2;

    cfg_t   cfg_reg, cfg_next;
    logic   beat_valid;
    logic   ev_valid;
    res_t   ev;
    res_t   head;

    // Registers take a write on any cycle
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LANE_COUNT: cfg_next.lane_count = cfg_data[LCNT_W-1:0];
                REG_OWN_FIRST:  cfg_next.own_first  = $signed(cfg_data[ADDR_BITS-1:0]);
                REG_OWN_SPAN:   cfg_next.own_span   = cfg_data[SPAN_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lane_count <= LCNT_W'(8);
            cfg_reg.own_first  <= '0;
            cfg_reg.own_span   <= SPAN_W'(1);
        end
        else
            cfg_reg <= cfg_next;
    end

    // Accept a beat only while the queue has room for its result
    assign beat_valid = push && !full;

    lbfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .lanes      (lanes),
        .cfg        (cfg_reg),
        .ev_valid   (ev_valid),
        .ev         (ev)
    );

    lbfd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (ev_valid),
        .wr_data (ev),
        .rd      (pop),
        .head    (head),
        .full    (full),
        .empty   (empty)
    );

    // Break the head word out onto the result ports
    assign kind       = head.kind;
    assign addressed  = head.addressed;
    assign src_first  = head.src_first;
    assign msg_total  = head.msg_total;
    assign dest       = head.dest;
    assign msg_index  = head.msg_index;
    assign item_index = head.item_index;
    assign word       = head.word;
    assign last       = head.last;

endmodule

`default_nettype wire

// ===== tb/lane_bus_frame_deframer_unit_tb.sv =====
// Self-checking testbench for lane_bus_frame_deframer_unit: drives lane words, config writes
// and result pops, and checks every result word against a frame-parsing scoreboard.
// Depends on lbfd_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module lane_bus_frame_deframer_unit_tb;

    import lbfd_pkg::*;

    // Cycles with no accepted word on any channel before the run is declared hung.
    // Worst honest gap: idle bursts on push, stall bursts on pop, the hold-off before config, the wait at the end.
    localparam int STALL_LIMIT = 2000;
    localparam int BROADCAST   = -1;
    localparam int PHASE_WORDS = 125;
    localparam int PHASES      = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LANE_COUNT = 0,
        REG_OWN_FIRST  = 1,
        REG_OWN_SPAN   = 2,
        REG_SPARE      = 3
    } cfg_reg_e;

    // Where the parser stands within a frame
    typedef enum logic [2:0] {
        AT_TYPE,
        AT_SOURCE,
        AT_COUNT,
        AT_DEST,
        AT_LENGTH,
        AT_VALUE,
        AT_TRAILER
    } frame_pos_e;

    // Tracks the frame being parsed, queues the result words it must produce and
    // checks popped result words against them in order.
    class frame_tracker;
        int lane_count = 8;
        int own_first  = 0;
        int own_span   = 1;

        frame_pos_e at = AT_TYPE;
        int acc        = 0;
        int nbits      = 0;
        int field_val  = 0;
        bit bad_type   = 1'b0;
        bit ours       = 1'b0;
        int src        = 0;
        int total      = 0;
        int dst        = 0;
        int msg_no     = 0;
        int item_no    = 0;
        int cur_len    = 0;
        int errors     = 0;

        res_t due_results[$];

        function int lanes_eff();
            if (lane_count == 0)
                return 1;
            if (lane_count > MAX_LANES)
                return MAX_LANES;
            return lane_count;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void set_reg(cfg_reg_e idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_LANE_COUNT: lane_count = int'(data[LCNT_W-1:0]);
                REG_OWN_FIRST:  own_first  = int'(signed'(data));
                REG_OWN_SPAN:   own_span   = int'(data[SPAN_W-1:0]);
                default: ;
            endcase
        endfunction

        // Shift this word's low lanes into the current field; 1 when the field is full.
        function bit gather(logic [LANE_W-1:0] w, int bits);
            int n;
            n = lanes_eff();
            if (n > bits - nbits)
                n = bits - nbits;
            acc   = acc | ((int'(w) & ((1 << n) - 1)) << nbits);
            nbits = nbits + n;
            if (nbits < bits)
                return 1'b0;
            field_val = (acc >= (1 << (bits - 1))) ? acc - (1 << bits) : acc;
            acc   = 0;
            nbits = 0;
            return 1'b1;
        endfunction

        function void queue_result(logic [KIND_W-1:0] k, int mi, int ii, int w, bit l);
            res_t r;
            r.kind       = k;
            r.addressed  = ours;
            r.src_first  = src[ADDR_BITS-1:0];
            r.msg_total  = total[COUNT_BITS-1:0];
            r.dest       = dst[ADDR_BITS-1:0];
            r.msg_index  = mi[MIDX_W-1:0];
            r.item_index = ii[IIDX_W-1:0];
            r.word       = w[WORD_W-1:0];
            r.last       = l;
            due_results.push_back(r);
        endfunction

        function void next_msg();
            msg_no  = msg_no + 1;
            item_no = 0;
            at = (msg_no >= total) ? AT_TRAILER : AT_LENGTH;
        endfunction

        // Advance the parse by one accepted lane word.
        function void take_word(logic [LANE_W-1:0] w);
            int mi;
            int ii;
            case (at)
                AT_TYPE:
                    if (gather(w, TYPE_BITS)) begin
                        bad_type = (field_val != 0);
                        at = AT_SOURCE;
                    end
                AT_SOURCE:
                    if (gather(w, ADDR_BITS)) begin
                        src = field_val;
                        at = AT_COUNT;
                    end
                AT_COUNT:
                    if (gather(w, COUNT_BITS)) begin
                        total = field_val;
                        at = AT_DEST;
                    end
                AT_DEST:
                    if (gather(w, ADDR_BITS)) begin
                        dst  = field_val;
                        ours = (dst == BROADCAST) ||
                               (dst >= own_first && dst < own_first + own_span);
                        msg_no  = 0;
                        item_no = 0;
                        if (bad_type) begin
                            at = AT_TYPE;
                            queue_result(KIND_UNSUP, 0, 0, 0, 1'b0);
                        end else begin
                            at = (total > 0) ? AT_LENGTH : AT_TRAILER;
                            queue_result(KIND_HDR, 0, 0, 0, 1'b0);
                        end
                    end
                AT_LENGTH:
                    if (gather(w, LEN_BITS)) begin
                        cur_len = field_val;
                        mi      = msg_no;
                        item_no = 0;
                        if (cur_len <= 0)
                            next_msg();
                        else
                            at = AT_VALUE;
                        if (ours)
                            queue_result(KIND_LEN, mi, 0, cur_len, 1'b0);
                    end
                AT_VALUE:
                    if (gather(w, VALUE_BITS)) begin
                        mi      = msg_no;
                        ii      = item_no;
                        item_no = item_no + 1;
                        if (item_no >= cur_len)
                            next_msg();
                        if (ours)
                            queue_result(KIND_VAL, mi, ii, field_val, 1'b0);
                    end
                AT_TRAILER:
                begin
                    at    = AT_TYPE;
                    acc   = 0;
                    nbits = 0;
                    queue_result(KIND_END, msg_no, 0, 0, 1'b1);
                end
                default:
                begin
                    at    = AT_TYPE;
                    acc   = 0;
                    nbits = 0;
                end
            endcase
        endfunction

        function void cmp(string name, int want, int seen);
            if (want != seen) begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void match_result(res_t got);
            res_t e;
            if (due_results.size() == 0) begin
                $display("%0t: result word of kind %0d with nothing outstanding",
                         $time, got.kind);
                errors++;
                return;
            end
            e = due_results.pop_front();
            cmp("kind",       int'(e.kind),       int'(got.kind));
            cmp("addressed",  int'(e.addressed),  int'(got.addressed));
            cmp("src_first",  int'(e.src_first),  int'(got.src_first));
            cmp("msg_total",  int'(e.msg_total),  int'(got.msg_total));
            cmp("dest",       int'(e.dest),       int'(got.dest));
            cmp("msg_index",  int'(e.msg_index),  int'(got.msg_index));
            cmp("item_index", int'(e.item_index), int'(got.item_index));
            cmp("word",       int'(e.word),       int'(got.word));
            cmp("last",       int'(e.last),       int'(got.last));
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          push      = 1'b0;
    logic [LANE_W-1:0]             lanes     = '0;
    logic                          pop       = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DAT_W-1:0]          cfg_data  = '0;

    logic                          full;
    logic                          empty;
    logic                          cfg_ready;
    logic [KIND_W-1:0]             kind;
    logic                          addressed;
    logic signed [ADDR_BITS-1:0]   src_first;
    logic signed [COUNT_BITS-1:0]  msg_total;
    logic signed [ADDR_BITS-1:0]   dest;
    logic [MIDX_W-1:0]             msg_index;
    logic [IIDX_W-1:0]             item_index;
    logic signed [WORD_W-1:0]      word;
    logic                          last;

    frame_tracker sb = new;

    // No idling on either side once set (final phase of the run)
    bit calm = 1'b0;
    int words_sent = 0;

    // Message body of the next frame: lengths, then all values in order
    int body_lens[$];
    int body_vals[$];

    lane_bus_frame_deframer_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .lanes      (lanes),
        .empty      (empty),
        .pop        (pop),
        .kind       (kind),
        .addressed  (addressed),
        .src_first  (src_first),
        .msg_total  (msg_total),
        .dest       (dest),
        .msg_index  (msg_index),
        .item_index (item_index),
        .word       (word),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Push one lane word and hold it until the block takes it. All handshake
    // signals are read right after the edge, so they carry their pre-edge values.
    task automatic send_word(input logic [LANE_W-1:0] w);
        if (!calm && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        push  <= 1'b1;
        lanes <= w;
        do
            @(posedge clk);
        while (full);
        words_sent++;
        sb.take_word(w);
    endtask

    // Split a field over as many words as the lane count needs, least significant
    // group first. Lanes above the group carry random junk that must be dropped.
    task automatic send_field(input int val, input int bits);
        int lc;
        int done_bits;
        int n;
        logic [LANE_W-1:0] mask;
        logic [LANE_W-1:0] beat;
        lc = sb.lanes_eff();
        done_bits = 0;
        while (done_bits < bits) begin
            n    = (bits - done_bits < lc) ? bits - done_bits : lc;
            mask = LANE_W'((1 << n) - 1);
            beat = (LANE_W'($urandom) & ~mask) | (LANE_W'(val >>> done_bits) & mask);
            send_word(beat);
            done_bits += n;
        end
    endtask

    // Send a header, then whatever body is queued, then optionally the empty trailer.
    task automatic send_frame(input int typ, input int src_v, input int cnt,
                              input int dst_v, input bit with_end);
        int len;
        send_field(typ, TYPE_BITS);
        send_field(src_v, ADDR_BITS);
        send_field(cnt, COUNT_BITS);
        send_field(dst_v, ADDR_BITS);
        while (body_lens.size() != 0) begin
            len = body_lens.pop_front();
            send_field(len, LEN_BITS);
            for (int k = 0; k < len; k++)
                send_field(body_vals.pop_front(), VALUE_BITS);
        end
        if (with_end)
            send_word(LANE_W'($urandom));
    endtask

    // Signed field value biased toward its extremes
    function automatic int pick_value(input int bits);
        case ($urandom_range(0, 7))
            0: return 0;
            1: return -1;
            2: return (1 << (bits - 1)) - 1;
            3: return -(1 << (bits - 1));
            default: return int'($urandom_range(0, (1 << bits) - 1));
        endcase
    endfunction

    // Mostly well-formed frames with random content; some unsupported types,
    // truncated frames and plain junk words to knock the parser off its rails.
    task automatic random_frame();
        int typ;
        int src_v;
        int cnt;
        int dst_v;
        int msgs;
        int len;
        bit with_end;
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 6)) send_word(LANE_W'($urandom));
            return;
        end
        typ   = ($urandom_range(0, 9) == 0) ? 1 : 0;
        src_v = pick_value(ADDR_BITS);
        case ($urandom_range(0, 9))
            0: cnt = -int'($urandom_range(1, 2048));
            1: cnt = 0;
            2: cnt = int'($urandom_range(4, 6));
            default: cnt = int'($urandom_range(1, 3));
        endcase
        // Aim the destination at the span edges and the broadcast address
        case ($urandom_range(0, 6))
            0: dst_v = BROADCAST;
            1: dst_v = sb.own_first;
            2: dst_v = sb.own_first + sb.own_span - 1;
            3: dst_v = sb.own_first + sb.own_span;
            4: dst_v = sb.own_first - 1;
            5: dst_v = pick_value(ADDR_BITS);
            default: dst_v = sb.own_first + int'($urandom_range(0, sb.own_span));
        endcase
        if (typ != 0) begin
            // Unsupported type drops back to idle; sometimes send a stray body anyway
            if ($urandom_range(0, 2) != 0) begin
                send_frame(typ, src_v, cnt, dst_v, 1'b0);
                return;
            end
            msgs = int'($urandom_range(0, 2));
            with_end = 1'b1;
        end else begin
            msgs = (cnt > 0) ? cnt : 0;
            with_end = ($urandom_range(0, 14) != 0);
        end
        for (int m = 0; m < msgs; m++) begin
            case ($urandom_range(0, 9))
                0: len = -int'($urandom_range(0, 32));
                1: len = (sb.lanes_eff() >= 8) ? int'($urandom_range(5, 31)) : 5;
                default: len = int'($urandom_range(0, 4));
            endcase
            body_lens.push_back(len);
            for (int k = 0; k < len; k++)
                body_vals.push_back(pick_value(VALUE_BITS));
        end
        send_frame(typ, src_v, cnt, dst_v, with_end);
    endtask

    // Write all registers back to back, the spare index included.
    // Bits above each register's width carry junk that must be ignored.
    task automatic configure(input int lc, input int first, input int span);
        logic [CFG_DAT_W-1:0] data [4];
        data[REG_LANE_COUNT] = {(CFG_DAT_W - LCNT_W)'($urandom), lc[LCNT_W-1:0]};
        data[REG_OWN_FIRST]  = first[CFG_DAT_W-1:0];
        data[REG_OWN_SPAN]   = {(CFG_DAT_W - SPAN_W)'($urandom), span[SPAN_W-1:0]};
        data[REG_SPARE]      = CFG_DAT_W'($urandom);
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= data[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.set_reg(cfg_reg_e'(i), data[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Bring the parser back to a frame boundary, drop push, drain every result
    // word and hold off a few cycles so the block is idle before a config write.
    task automatic settle();
        while (sb.at != AT_TYPE)
            send_word('0);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Result side: check each popped word, stall in short random bursts
    initial
    begin : result_side
        int hold;
        res_t got;
        hold = 0;
        forever begin
            @(posedge clk);
            if (pop && !empty) begin
                got.kind       = kind;
                got.addressed  = addressed;
                got.src_first  = src_first;
                got.msg_total  = msg_total;
                got.dest       = dest;
                got.msg_index  = msg_index;
                got.item_index = item_index;
                got.word       = word;
                got.last       = last;
                sb.match_result(got);
            end
            if (hold > 0) begin
                hold--;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold = int'($urandom_range(0, 2));
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if no word moves on any channel for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int target;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames, one field per word, own span is address 0 alone
        configure(MAX_LANES, 0, 1);
        // Negative count (no messages), destination outside the span
        send_frame(0, 0, -2048, 1, 1'b1);
        // Unsupported type: header fields, no trailer, back to idle
        send_frame(1, -32768, 2047, 0, 1'b0);
        // Broadcast frame with an empty and a negative-length message
        body_lens = '{0, -32};
        send_frame(0, -1, 2, BROADCAST, 1'b1);
        // Addressed frame, values at the extremes
        body_lens = '{3};
        body_vals = '{2047, -2048, -1};
        send_frame(0, 32767, 1, 0, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: configure(1, -32768, 2047);
                1: configure(MAX_LANES, 32767, 1);
                2: configure(0, 100, 0);           // lane count zero, empty span
                3: configure(31, -5, 10);          // lane count beyond the bus width
                default: configure(int'($urandom_range(1, MAX_LANES)),
                                   pick_value(ADDR_BITS),
                                   int'($urandom_range(0, 2047)));
            endcase
            calm = (p == PHASES - 1);
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
                random_frame();
        end

        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // Catch any stray result words the block still holds
        repeat (16) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
